### sv/nnls_pkg.sv
// ----------------------------------------------------------------------------
// nnls_pkg
// Types and fixed constants shared by the NNLS spectral unmixing block and
// its shared divider.
// ----------------------------------------------------------------------------
package nnls_pkg;

  localparam int GRAM_W  = 40;
  localparam int GRAD_W  = 48;
  localparam int COEF_W  = 32;
  localparam int CFG_W   = 24;
  localparam int DIV_W   = 64;
  localparam int DIVR_W  = 40;
  localparam int STEP_CW = 7;
  localparam int STEPV_W = 58;

  localparam logic [2:0] REG_NUM_ENDMEMBERS = 3'd0;
  localparam logic [2:0] REG_NUM_BANDS      = 3'd1;
  localparam logic [2:0] REG_MAX_ITERATIONS = 3'd2;
  localparam logic [2:0] REG_TOLERANCE      = 3'd3;
  localparam logic [2:0] REG_RMSE_ENABLE    = 3'd4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic KIND_FRACTION = 1'b0;
  localparam logic KIND_RMSE     = 1'b1;

  localparam logic [STEP_CW-1:0] STEPS_COORD = 7'd57;
  localparam logic [STEP_CW-1:0] STEPS_MEAN  = 7'd64;
  localparam logic [STEP_CW-1:0] STEPS_FRAC  = 7'd48;

  localparam logic [63:0] GRAM_CAP = 64'h0000_00FF_FFFF_FFFF;
  localparam logic [63:0] GRAD_CAP = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] PRED_CAP = 64'h4000_0000_0000_0000;
  localparam logic [COEF_W-1:0] COEF_CAP = 32'hFFFF_FFFF;
  localparam logic [STEPV_W-1:0] STEP_CAP = 58'h2_0000_0000;
  localparam logic [29:0] D8_CAP = 30'h2000_0000;
  localparam logic [23:0] RMSE_CAP = 24'hFF_FFFF;

  typedef struct packed {
    logic        op;
    logic [2:0]  endmember_index;
    logic [4:0]  band_index;
    logic [15:0] sample_value;
    logic        is_last;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  fraction_index;
    logic [23:0] result_value;
    logic        degenerate;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic               start;
    logic [DIVR_W-1:0]  rem;
    logic [DIV_W-1:0]   bits;
    logic [STEP_CW-1:0] steps;
    logic [DIVR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

### sv/nnls_div.sv
// ----------------------------------------------------------------------------
// nnls_div
// Restoring divider, one quotient bit per cycle, shared by the coordinate
// step, the RMSE mean and the fraction normalisation.
// ----------------------------------------------------------------------------
module nnls_div (
  input  logic              clk,
  input  logic              rst,
  input  nnls_pkg::div_req_t req,
  output nnls_pkg::div_rsp_t rsp
);
  import nnls_pkg::*;

  logic [DIVR_W-1:0]  rem;
  logic [DIVR_W-1:0]  divisor;
  logic [DIV_W-1:0]   bits;
  logic [DIV_W-1:0]   quot;
  logic [STEP_CW-1:0] cnt;
  logic               run;
  logic               done;
  logic [DIVR_W:0]    trial;
  logic [DIVR_W:0]    diff;
  logic               fits;

  always_comb begin
    trial = {rem, bits[DIV_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      rem     <= req.rem;
      bits    <= req.bits;
      cnt     <= req.steps;
      divisor <= req.divisor;
      quot    <= '0;
      run     <= 1'b1;
      done    <= 1'b0;
    end else if (run) begin
      rem  <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      bits <= {bits[DIV_W-2:0], 1'b0};
      quot <= {quot[DIV_W-2:0], fits};
      cnt  <= cnt - 1'b1;
      if (cnt == STEP_CW'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

### sv/nnls_spectral_unmixing.sv
// ----------------------------------------------------------------------------
// nnls_spectral_unmixing
// NNLS unmixing by projected coordinate descent: Gram matrix formed on the
// last endmember word, per-pixel solve on the last sample, normalised
// fractions then an optional RMSE item.
// ----------------------------------------------------------------------------
// Gram formation: all MAX_ENDMEMBERS^2 entries, each a sum over nb bands.
// Pixel solve: the gradient over ne*nb products, then per sweep and coordinate
// a division on the shared divider (57 steps) where needed, then ne updates.
// RMSE: nb residuals, a mean division, a square root; fractions: a division each.
// Results leave one per strobe; busy is high from the last item to the end.
// Synchronous reset restores register defaults; stores are undefined.
module nnls_spectral_unmixing #(
  parameter int MAX_ENDMEMBERS = 8,
  parameter int MAX_BANDS      = 32,
  parameter int SAMPLE_WIDTH   = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  nnls_pkg::item_t           item,
  output logic                      busy,
  output nnls_pkg::result_t         result,
  output logic                      result_valid,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [nnls_pkg::CFG_W-1:0] cfg_data
);
  import nnls_pkg::*;

  localparam int ME    = MAX_ENDMEMBERS;
  localparam int MB    = MAX_BANDS;
  localparam int KW    = (ME > 1) ? $clog2(ME) : 1;
  localparam int BW    = (MB > 1) ? $clog2(MB) : 1;
  localparam int AW    = (ME * MB > 1) ? $clog2(ME * MB) : 1;
  localparam int GAW   = (ME * ME > 1) ? $clog2(ME * ME) : 1;
  localparam int SWS   = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;
  localparam int TOT_W = COEF_W + KW + 1;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_G_ADDR   = 5'd1;
  localparam logic [4:0] S_G_MUL    = 5'd2;
  localparam logic [4:0] S_G_ACC    = 5'd3;
  localparam logic [4:0] S_GI_ADDR  = 5'd4;
  localparam logic [4:0] S_GI_MUL   = 5'd5;
  localparam logic [4:0] S_GI_ACC   = 5'd6;
  localparam logic [4:0] S_CD_ADDR  = 5'd7;
  localparam logic [4:0] S_CD_CHK   = 5'd8;
  localparam logic [4:0] S_CD_DIV   = 5'd9;
  localparam logic [4:0] S_CD_NEW   = 5'd10;
  localparam logic [4:0] S_UP_ADDR  = 5'd11;
  localparam logic [4:0] S_UP_MUL   = 5'd12;
  localparam logic [4:0] S_UP_ACC   = 5'd13;
  localparam logic [4:0] S_RM_ADDR  = 5'd14;
  localparam logic [4:0] S_RM_MUL   = 5'd15;
  localparam logic [4:0] S_RM_ACC   = 5'd16;
  localparam logic [4:0] S_RM_RES   = 5'd17;
  localparam logic [4:0] S_RM_SQ    = 5'd18;
  localparam logic [4:0] S_RM_SUM   = 5'd19;
  localparam logic [4:0] S_RM_DIV   = 5'd20;
  localparam logic [4:0] S_SQRT     = 5'd21;
  localparam logic [4:0] S_TOT      = 5'd22;
  localparam logic [4:0] S_FR_START = 5'd23;
  localparam logic [4:0] S_FR_DIV   = 5'd24;
  localparam logic [4:0] S_RM_OUT   = 5'd25;

  // configuration
  logic [3:0]  num_endmembers;
  logic [5:0]  num_bands;
  logic [15:0] max_iterations;
  logic [23:0] tolerance;
  logic        rmse_enable;

  // memories
  logic [SWS-1:0]    store [ME*MB];
  logic [GRAM_W-1:0] gram  [ME*ME];
  logic [SWS-1:0]    pix   [MB];
  logic [SWS-1:0]    st_qa, st_qb, pix_q;
  logic [GRAM_W-1:0] gram_q;

  logic [COEF_W-1:0]        coef [ME];
  logic signed [GRAD_W-1:0] grad [ME];

  // sequencer
  logic [4:0]         state;
  logic [KW-1:0]      k, l, ne_m1;
  logic [BW-1:0]      b, nb_m1;
  logic [15:0]        iter;
  logic [COEF_W-1:0]  maxd, nw_r, ad_r;
  logic               down_r;
  logic [STEPV_W-1:0] step;
  logic [63:0]        acc, prod, sum;
  logic [GRAM_W+7:0]  ph;
  logic [63:0]        pl;
  logic [29:0]        d8;
  logic [63:0]        sq_v, sq_res, sq_bit;
  logic [4:0]         sq_cnt;
  logic [23:0]        rm;
  logic [TOT_W-1:0]   total;
  logic               degen;

  div_req_t div_req;
  div_rsp_t div_rsp;

  nnls_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // combinational helpers
  int                 ne_eff, nb_eff;
  logic               accept, last_k, last_b, sweep_stop;
  logic [4:0]         post_state, adv_state;
  logic [AW-1:0]      st_addr_a, st_addr_b, st_waddr;
  logic [GAW-1:0]     gram_raddr, gram_waddr;
  logic [BW-1:0]      pix_waddr;
  logic               st_we, pix_we, gram_we;
  logic [63:0]        sat_cap, acc_sat, sum_sat;
  logic [64:0]        acc_sum, sum_sum;
  logic [2*SWS-1:0]   p_ss, p_sp;
  logic [COEF_W+SWS-1:0] p_cs;
  logic [GRAM_W+7:0]  p_hi;
  logic [GRAM_W+23:0] p_lo;
  logic [59:0]        p_sq;
  logic [GRAD_W-1:0]  mag;
  logic               step_clamp, gpos;
  logic [COEF_W-1:0]  old, nw_dn, nw_up, nw, ad;
  logic [STEPV_W:0]   s_up;
  logic [64:0]        pl_rnd;
  logic [49:0]        term;
  logic signed [50:0] gx, tx, vx;
  logic [63:0]        xs, rm_mag, rm_r;
  logic [29:0]        d8_nx;
  logic [63:0]        sq_try, res_nx;
  logic               sq_ge;
  logic [47:0]        frac_num;
  logic [TOT_W-1:0]   total_nx;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    ne_eff = (num_endmembers == 4'd0) ? 1 :
             ((int'(num_endmembers) > ME) ? ME : int'(num_endmembers));
    nb_eff = (num_bands == 6'd0) ? 1 :
             ((int'(num_bands) > MB) ? MB : int'(num_bands));
  end

  always_comb begin
    last_k     = (k == ne_m1);
    last_b     = (b == nb_m1);
    sweep_stop = (maxd <= COEF_W'(tolerance)) ||
                 ((17'(iter) + 17'd1) >= 17'(max_iterations));
    post_state = rmse_enable ? S_RM_ADDR : S_TOT;
    adv_state  = (last_k && sweep_stop) ? post_state : S_CD_ADDR;
  end

  // memory addressing
  always_comb begin
    st_addr_a  = AW'(int'(k) * MB + int'(b));
    st_addr_b  = AW'(int'(l) * MB + int'(b));
    st_waddr   = AW'(int'(item.endmember_index) * MB + int'(item.band_index));
    pix_waddr  = BW'(item.band_index);
    st_we      = accept && (item.op == OP_LOAD) &&
                 (int'(item.endmember_index) < ME) && (int'(item.band_index) < MB);
    pix_we     = accept && (item.op == OP_PIXEL) && (int'(item.band_index) < MB);
    gram_raddr = (state == S_CD_ADDR || state == S_CD_CHK) ?
                 GAW'(int'(k) * ME + int'(k)) : GAW'(int'(l) * ME + int'(k));
    gram_waddr = GAW'(int'(k) * ME + int'(l));
    gram_we    = (state == S_G_ACC) && last_b;
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_waddr] <= item.sample_value[SWS-1:0];
    end
    st_qa <= store[st_addr_a];
    st_qb <= store[st_addr_b];
    if (pix_we) begin
      pix[pix_waddr] <= item.sample_value[SWS-1:0];
    end
    pix_q <= pix[b];
    if (gram_we) begin
      gram[gram_waddr] <= acc_sat[GRAM_W-1:0];
    end
    gram_q <= gram[gram_raddr];
  end

  // datapath
  always_comb begin
    case (state)
      S_G_ACC:  sat_cap = GRAM_CAP;
      S_GI_ACC: sat_cap = GRAD_CAP;
      default:  sat_cap = PRED_CAP;
    endcase
    acc_sum = {1'b0, acc} + {1'b0, prod};
    acc_sat = (acc_sum > {1'b0, sat_cap}) ? sat_cap : acc_sum[63:0];
    sum_sum = {1'b0, sum} + {1'b0, prod};
    sum_sat = sum_sum[64] ? '1 : sum_sum[63:0];

    p_ss = st_qa * st_qb;
    p_sp = st_qa * pix_q;
    p_cs = coef[k] * st_qa;
    p_hi = gram_q * ad_r[31:24];
    p_lo = gram_q * ad_r[23:0];
    p_sq = d8 * d8;

    mag        = grad[k][GRAD_W-1] ? GRAD_W'(-grad[k]) : GRAD_W'(grad[k]);
    step_clamp = (mag >> 33) >= GRAD_W'(gram_q);

    old   = coef[k];
    gpos  = !grad[k][GRAD_W-1] && (grad[k] != '0);
    nw_dn = (step >= STEPV_W'(old)) ? '0 : old - step[COEF_W-1:0];
    s_up  = (STEPV_W+1)'(old) + (STEPV_W+1)'(step);
    nw_up = (s_up > (STEPV_W+1)'(COEF_CAP)) ? COEF_CAP : s_up[COEF_W-1:0];
    nw    = gpos ? nw_dn : nw_up;
    ad    = gpos ? old - nw : nw - old;

    pl_rnd = {1'b0, pl} + 65'h80_0000;
    term   = {2'b00, ph} + 50'(pl_rnd >> 24);
    gx     = {{3{grad[l][GRAD_W-1]}}, grad[l]};
    tx     = $signed({1'b0, term});
    vx     = down_r ? gx - tx : gx + tx;

    xs     = 64'({pix_q, 24'b0});
    rm_mag = (acc > xs) ? acc - xs : xs - acc;
    rm_r   = (rm_mag + 64'h8000) >> 16;
    d8_nx  = (rm_r > 64'(D8_CAP)) ? D8_CAP : rm_r[29:0];

    sq_try = sq_res + sq_bit;
    sq_ge  = sq_v >= sq_try;
    res_nx = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;

    frac_num = 48'({coef[k], 15'b0}) + 48'(total >> 1);
    total_nx = total + TOT_W'(coef[k]);
  end

  always_comb begin
    div_req = '0;
    case (state)
      S_CD_CHK: begin
        div_req.start   = (gram_q != '0) && !step_clamp;
        div_req.rem     = DIVR_W'(mag >> 33);
        div_req.bits    = {mag[32:0], 31'b0};
        div_req.steps   = STEPS_COORD;
        div_req.divisor = gram_q;
      end
      S_RM_SUM: begin
        div_req.start   = last_b;
        div_req.bits    = sum_sat;
        div_req.steps   = STEPS_MEAN;
        div_req.divisor = DIVR_W'(nb_m1) + DIVR_W'(1);
      end
      S_FR_START: begin
        div_req.start   = !degen;
        div_req.bits    = {frac_num, 16'b0};
        div_req.steps   = STEPS_FRAC;
        div_req.divisor = DIVR_W'(total);
      end
      default: div_req = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_endmembers <= 4'd4;
      num_bands      <= 6'd8;
      max_iterations <= 16'd400;
      tolerance      <= 24'd17;
      rmse_enable    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_ENDMEMBERS: num_endmembers <= cfg_data[3:0];
        REG_NUM_BANDS:      num_bands      <= cfg_data[5:0];
        REG_MAX_ITERATIONS: max_iterations <= cfg_data[15:0];
        REG_TOLERANCE:      tolerance      <= cfg_data[23:0];
        REG_RMSE_ENABLE:    rmse_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      iter         <= '0;
      for (int i = 0; i < ME; i++) begin
        coef[i] <= '0;
        grad[i] <= '0;
      end
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && item.is_last) begin
            k     <= '0;
            l     <= '0;
            b     <= '0;
            acc   <= '0;
            nb_m1 <= BW'(nb_eff - 1);
            if (item.op == OP_LOAD) begin
              state <= S_G_ADDR;
            end else begin
              ne_m1 <= KW'(ne_eff - 1);
              for (int i = 0; i < ME; i++) begin
                coef[i] <= '0;
                grad[i] <= '0;
              end
              state <= S_GI_ADDR;
            end
          end
        end

        S_G_ADDR: state <= S_G_MUL;
        S_G_MUL: begin
          prod  <= 64'(p_ss);
          state <= S_G_ACC;
        end
        S_G_ACC: begin
          state <= S_G_ADDR;
          if (last_b) begin
            acc <= '0;
            b   <= '0;
            if (l == KW'(ME - 1)) begin
              l <= '0;
              if (k == KW'(ME - 1)) begin
                state <= S_IDLE;
              end else begin
                k <= k + 1'b1;
              end
            end else begin
              l <= l + 1'b1;
            end
          end else begin
            acc <= acc_sat;
            b   <= b + 1'b1;
          end
        end

        S_GI_ADDR: state <= S_GI_MUL;
        S_GI_MUL: begin
          prod  <= 64'(p_sp);
          state <= S_GI_ACC;
        end
        S_GI_ACC: begin
          state <= S_GI_ADDR;
          if (last_b) begin
            grad[k] <= -$signed(acc_sat[GRAD_W-1:0]);
            acc     <= '0;
            b       <= '0;
            if (last_k) begin
              k     <= '0;
              iter  <= '0;
              maxd  <= '0;
              sum   <= '0;
              total <= '0;
              state <= (max_iterations == 16'd0) ? post_state : S_CD_ADDR;
            end else begin
              k <= k + 1'b1;
            end
          end else begin
            acc <= acc_sat;
            b   <= b + 1'b1;
          end
        end

        S_CD_ADDR: state <= S_CD_CHK;
        S_CD_CHK: begin
          if (gram_q == '0) begin
            state <= adv_state;
            if (last_k) begin
              k    <= '0;
              iter <= iter + 1'b1;
              maxd <= '0;
            end else begin
              k <= k + 1'b1;
            end
          end else if (step_clamp) begin
            step  <= STEP_CAP;
            state <= S_CD_NEW;
          end else begin
            state <= S_CD_DIV;
          end
        end
        S_CD_DIV: begin
          if (div_rsp.done) begin
            step  <= STEPV_W'(div_rsp.quot[56:0]);
            state <= S_CD_NEW;
          end
        end
        S_CD_NEW: begin
          if (nw == old) begin
            state <= adv_state;
            if (last_k) begin
              k    <= '0;
              iter <= iter + 1'b1;
              maxd <= '0;
            end else begin
              k <= k + 1'b1;
            end
          end else begin
            nw_r   <= nw;
            ad_r   <= ad;
            down_r <= gpos;
            if (ad > maxd) begin
              maxd <= ad;
            end
            l     <= '0;
            state <= S_UP_ADDR;
          end
        end

        S_UP_ADDR: state <= S_UP_MUL;
        S_UP_MUL: begin
          ph    <= p_hi;
          pl    <= 64'(p_lo);
          state <= S_UP_ACC;
        end
        S_UP_ACC: begin
          if (vx > 51'sh7FFF_FFFF_FFFF) begin
            grad[l] <= 48'sh7FFF_FFFF_FFFF;
          end else if (vx < -51'sh7FFF_FFFF_FFFF) begin
            grad[l] <= -48'sh7FFF_FFFF_FFFF;
          end else begin
            grad[l] <= vx[GRAD_W-1:0];
          end
          if (l == ne_m1) begin
            coef[k] <= nw_r;
            state   <= adv_state;
            if (last_k) begin
              k    <= '0;
              iter <= iter + 1'b1;
              maxd <= '0;
            end else begin
              k <= k + 1'b1;
            end
          end else begin
            l     <= l + 1'b1;
            state <= S_UP_ADDR;
          end
        end

        S_RM_ADDR: state <= S_RM_MUL;
        S_RM_MUL: begin
          prod  <= 64'(p_cs);
          state <= S_RM_ACC;
        end
        S_RM_ACC: begin
          acc <= acc_sat;
          if (last_k) begin
            state <= S_RM_RES;
          end else begin
            k     <= k + 1'b1;
            state <= S_RM_ADDR;
          end
        end
        S_RM_RES: begin
          d8    <= d8_nx;
          state <= S_RM_SQ;
        end
        S_RM_SQ: begin
          prod  <= 64'(p_sq);
          state <= S_RM_SUM;
        end
        S_RM_SUM: begin
          sum <= sum_sat;
          acc <= '0;
          k   <= '0;
          if (last_b) begin
            state <= S_RM_DIV;
          end else begin
            b     <= b + 1'b1;
            state <= S_RM_ADDR;
          end
        end
        S_RM_DIV: begin
          if (div_rsp.done) begin
            sq_v   <= div_rsp.quot;
            sq_res <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            sq_cnt <= 5'd31;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_v <= sq_v - sq_try;
          end
          sq_res <= res_nx;
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt - 1'b1;
          if (sq_cnt == 5'd0) begin
            rm    <= (res_nx > 64'(RMSE_CAP)) ? RMSE_CAP : res_nx[23:0];
            k     <= '0;
            total <= '0;
            state <= S_TOT;
          end
        end

        S_TOT: begin
          total <= total_nx;
          if (last_k) begin
            degen <= (total_nx == '0);
            k     <= '0;
            state <= S_FR_START;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_FR_START, S_FR_DIV: begin
          if ((state == S_FR_START && degen) || (state == S_FR_DIV && div_rsp.done)) begin
            result_valid          <= 1'b1;
            result.result_kind    <= KIND_FRACTION;
            result.fraction_index <= 3'(k);
            result.result_value   <= degen ? 24'd0 : div_rsp.quot[23:0];
            result.degenerate     <= degen;
            result.last_result    <= !rmse_enable && last_k;
            if (last_k) begin
              state <= rmse_enable ? S_RM_OUT : S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_FR_START;
            end
          end else if (state == S_FR_START) begin
            state <= S_FR_DIV;
          end
        end
        S_RM_OUT: begin
          result_valid          <= 1'b1;
          result.result_kind    <= KIND_RMSE;
          result.fraction_index <= 3'd0;
          result.result_value   <= rm;
          result.degenerate     <= degen;
          result.last_result    <= 1'b1;
          state                 <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rmse_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.result_kind == KIND_RMSE) |-> result.last_result)
    else $error("rmse item not marked last");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate && (result.result_kind == KIND_FRACTION)
    |-> (result.result_value == 24'd0))
    else $error("degenerate fraction not zero");

  a_solve_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (item.op == OP_PIXEL) && item.is_last |=> busy)
    else $error("solve did not start");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_CD_DIV || state == S_RM_DIV || state == S_FR_DIV))
    else $error("divider result with no waiting state");

endmodule
